// ===== rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types and constants of the frame pacing timer.
// ----------------------------------------------------------------------------
package fpt_pkg;

    // field widths
    localparam int PeriodW  = 24;
    localparam int TimeW    = 48;
    localparam int CountW   = 32;
    localparam int SpanW    = CountW + PeriodW;
    localparam int TargetW  = SpanW + 1;
    localparam int DiffW    = TargetW + 1;
    localparam int SatW     = 32;
    localparam int ElapsedW = 33;

    // period used when the register holds zero, also the reset value
    localparam logic [PeriodW-1:0] DefaultPeriod = 24'd16667;

    // default bound on skipped frames counted into the elapsed time
    localparam int MaxSkipDefault = 4;

    // operation codes
    typedef enum logic [1:0] {
        OP_START     = 2'd0,
        OP_WAIT      = 2'd1,
        OP_QUERY     = 2'd2,
        OP_RESET_LAG = 2'd3
    } fpt_op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ORIGIN,
        ST_TARGET,
        ST_DIFF,
        ST_RESULT,
        ST_DIV,
        ST_ELAPSED,
        ST_DONE
    } fpt_state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } fpt_div_stat_t;

endpackage

// ===== rtl/fpt_div.sv =====
// ----------------------------------------------------------------------------
// fpt_div
// Restoring bit-serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fpt_div
    import fpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TimeW-1:0]    dividend,
    input  logic [PeriodW-1:0]  divisor,
    output fpt_div_stat_t       stat,
    output logic [TimeW-1:0]    quotient
);

    localparam int CntW = $clog2(TimeW);
    localparam logic [CntW-1:0] LastStep = CntW'(TimeW - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CntW-1:0]     cnt_reg;
    logic [PeriodW-1:0]  rem_reg;
    logic [TimeW-1:0]    quo_reg;
    logic [PeriodW-1:0]  divisor_reg;

    logic [PeriodW:0]    trial;
    logic [PeriodW+1:0]  trial_diff;
    logic                fits;
    logic [PeriodW-1:0]  rem_next;
    logic [TimeW-1:0]    quo_next;

    // one trial subtraction
    always_comb
    begin
        trial      = {rem_reg, quo_reg[TimeW-1]};
        trial_diff = {1'b0, trial} - {2'b00, divisor_reg};
        fits       = !trial_diff[PeriodW+1];
        rem_next   = fits ? trial_diff[PeriodW-1:0] : trial[PeriodW-1:0];
        quo_next   = {quo_reg[TimeW-2:0], fits};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/frame_pacing_timer.sv =====
// ----------------------------------------------------------------------------
// frame_pacing_timer
// Fixed-rate frame pacer with frame skip on integer microsecond timestamps.
// ----------------------------------------------------------------------------
// Usage: each input item carries an operation (start, wait, query, reset lag)
// and the current time from a free-running timebase; every item gives exactly
// one result item. The cfg channel writes the frame period; it is always
// ready; the user must write it only while the block is idle, which the
// block does not enforce. A period change is a cfg write followed by a
// reset-lag item. Start goes to done; reset lag runs multiply and origin;
// query and on-time wait run multiply, target, diff, result; a late wait
// adds the 48-step bit-serial divide of lag by period and elapsed. One shared
// 32x24 multiplier forms frames times period and the nominal elapsed time.
// Throughput: one item at a time; in_ready is high only while the sequencer
// is idle and the previous result has been handed to the output register.
// Reset: period returns to 16667, origin and frame count clear to zero.
// Stall: a result waits in the output register while out_ready is low; the
// next item may be accepted meanwhile and waits, fully computed, in the done
// step until the output register frees.
// ----------------------------------------------------------------------------
module frame_pacing_timer
    import fpt_pkg::*;
#(
    parameter int MAX_SKIP = MaxSkipDefault
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [PeriodW-1:0]          cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  operation,
    input  logic [TimeW-1:0]            now,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [TimeW-1:0]     remaining_ticks,
    output logic [SatW-1:0]             delay_ticks,
    output logic [SatW-1:0]             dropped_frames,
    output logic [ElapsedW-1:0]         elapsed_ticks
);

    localparam int SkipW = $clog2(MAX_SKIP + 1);

    // control state
    fpt_state_t             state_reg, state_next;
    logic                   out_valid_reg;
    logic [PeriodW-1:0]     period_reg;
    logic [TimeW-1:0]       origin_reg;
    logic [CountW-1:0]      count_reg;

    // working registers
    fpt_op_t                op_reg;
    logic [TimeW-1:0]       now_reg;
    logic [SpanW-1:0]       prod_reg;
    logic [TargetW-1:0]     target_reg;
    logic [DiffW-1:0]       diff_reg;
    logic [SkipW-1:0]       bounded_reg;
    logic [TimeW-1:0]       res_remaining_reg;
    logic [SatW-1:0]        res_delay_reg;
    logic [SatW-1:0]        res_skipped_reg;
    logic [ElapsedW-1:0]    res_elapsed_reg;
    logic [TimeW-1:0]       out_remaining_reg;
    logic [SatW-1:0]        out_delay_reg;
    logic [SatW-1:0]        out_skipped_reg;
    logic [ElapsedW-1:0]    out_elapsed_reg;

    // combinational
    logic [PeriodW-1:0]     eff_period;
    logic [CountW-1:0]      mul_a;
    logic [SpanW-1:0]       mul_p;
    logic [DiffW-1:0]       neg_diff;
    logic                   div_start;
    fpt_div_stat_t          div_stat;
    logic [TimeW-1:0]       quotient;
    logic                   in_take;
    logic                   out_load;
    logic [TimeW-1:0]       sat_remaining;
    logic [SatW-1:0]        sat_delay;
    logic [SatW-1:0]        sat_skipped;
    logic [SkipW-1:0]       bounded_next;

    // effective period, zero selects the default
    assign eff_period = (period_reg == '0) ? DefaultPeriod : period_reg;

    // shared multiplier: frames times period, or (1 + bounded skips) times period
    assign mul_a = (state_reg == ST_ELAPSED) ? (CountW'(bounded_reg) + 1'b1) : count_reg;
    assign mul_p = mul_a * SpanW'(eff_period);

    // saturation and lag
    always_comb
    begin
        neg_diff = '0 - diff_reg;
        if (diff_reg[DiffW-1:TimeW-1] == '0 || diff_reg[DiffW-1:TimeW-1] == '1)
        begin
            sat_remaining = diff_reg[TimeW-1:0];
        end
        else
        begin
            sat_remaining = diff_reg[DiffW-1] ? {1'b1, {(TimeW-1){1'b0}}}
                                              : {1'b0, {(TimeW-1){1'b1}}};
        end
        sat_delay   = (diff_reg[DiffW-1:SatW] != '0) ? '1 : diff_reg[SatW-1:0];
        sat_skipped = (quotient[TimeW-1:SatW] != '0) ? '1 : quotient[SatW-1:0];
        bounded_next = (quotient > TimeW'(MAX_SKIP)) ? SkipW'(MAX_SKIP)
                                                     : quotient[SkipW-1:0];
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign div_start = (state_reg == ST_RESULT) && (op_reg == OP_WAIT) && diff_reg[DiffW-1];
    assign cfg_ready = 1'b1;

    // lag divided by period
    fpt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (neg_diff[TimeW-1:0]),
        .divisor  (eff_period),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (fpt_op_t'(operation) == OP_START) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:     state_next = (op_reg == OP_RESET_LAG) ? ST_ORIGIN : ST_TARGET;
            ST_ORIGIN:  state_next = ST_DONE;
            ST_TARGET:  state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_RESULT;
            ST_RESULT:  state_next = div_start ? ST_DIV : ST_DONE;
            ST_DIV:     state_next = div_stat.done ? ST_ELAPSED : ST_DIV;
            ST_ELAPSED: state_next = ST_DONE;
            ST_DONE:    state_next = out_load ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            period_reg    <= DefaultPeriod;
            origin_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                period_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_take)
            begin
                case (fpt_op_t'(operation))
                    OP_START:
                    begin
                        origin_reg <= now;
                        count_reg  <= '0;
                    end
                    OP_WAIT:  count_reg <= count_reg + 1'b1;
                    default:  ;
                endcase
            end
            if (state_reg == ST_ORIGIN)
            begin
                origin_reg <= (prod_reg > SpanW'(now_reg)) ? '0
                                                           : now_reg - prod_reg[TimeW-1:0];
            end
            if (state_reg == ST_DIV && div_stat.done)
            begin
                count_reg <= count_reg + quotient[CountW-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg            <= fpt_op_t'(operation);
            now_reg           <= now;
            res_remaining_reg <= '0;
            res_delay_reg     <= '0;
            res_skipped_reg   <= '0;
            res_elapsed_reg   <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_TARGET)
        begin
            target_reg <= TargetW'(origin_reg) + TargetW'(prod_reg);
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= DiffW'(target_reg) - DiffW'(now_reg);
        end
        if (state_reg == ST_RESULT)
        begin
            res_remaining_reg <= sat_remaining;
            if (op_reg == OP_WAIT && !diff_reg[DiffW-1])
            begin
                res_delay_reg   <= sat_delay;
                res_elapsed_reg <= ElapsedW'(eff_period);
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            res_skipped_reg <= sat_skipped;
            bounded_reg     <= bounded_next;
        end
        if (state_reg == ST_ELAPSED)
        begin
            res_elapsed_reg <= mul_p[ElapsedW-1:0];
        end
        if (out_load)
        begin
            out_remaining_reg <= res_remaining_reg;
            out_delay_reg     <= res_delay_reg;
            out_skipped_reg   <= res_skipped_reg;
            out_elapsed_reg   <= res_elapsed_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign remaining_ticks = out_remaining_reg;
    assign delay_ticks     = out_delay_reg;
    assign dropped_frames  = out_skipped_reg;
    assign elapsed_ticks   = out_elapsed_reg;

    // a result with skipped frames is a late wait: negative remaining, no delay
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped_frames != '0) |-> (delay_ticks == '0 && remaining_ticks[TimeW-1]))
    else $error("skipped frames reported on a result that is not late");

    // a nonzero delay only comes from an on-time wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && delay_ticks != '0) |-> (dropped_frames == '0 && !remaining_ticks[TimeW-1]))
    else $error("sleep delay reported on a late result");

    // the divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
    else $error("divider finished outside the divide step");

endmodule
